### rtl/mac_pkg.sv
// shared types and constants for the moving average crossover detector
// no dependencies; imported by every rtl module of the block but mac_ram
package mac_pkg;

    localparam int MAX_WINDOW_DEF = 256;
    localparam int PRICE_BITS_DEF = 32;

    // running sums wrap at this width
    localparam int SUM_W = 40;

    // configuration register layout
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_FAST_WINDOW = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_WINDOW = 1'b1;

    localparam logic [CFG_W-1:0] FAST_WINDOW_RESET = 9'd10;
    localparam logic [CFG_W-1:0] SLOW_WINDOW_RESET = 9'd30;

    typedef enum logic [1:0] {
        REL_EQUAL   = 2'd0,
        REL_GREATER = 2'd1,
        REL_LESS    = 2'd2
    } t_relation;

    typedef enum logic [1:0] {
        CROSS_NONE = 2'd0,
        CROSS_UP   = 2'd1,
        CROSS_DOWN = 2'd2
    } t_cross;

    // stage load strobes from the pipeline control in the top level
    typedef struct packed {
        logic load_s1;
        logic load_s2;
        logic load_s3;
        logic load_out;
    } t_pipe_ctl;

endpackage

### rtl/moving_average_crossover_detector_top.sv
// moving average crossover detector, top level: config registers and pipeline control
// depends on mac_pkg, mac_hist, mac_accum, mac_cross (and mac_ram below mac_hist)
//
//  channel  | handshake           | payload
//  ---------+---------------------+-----------------------------------------
//  input    | i_valid / o_stall   | i_price, i_start_of_series
//  output   | o_valid / i_stall   | o_cross_signal
//  config   | i_cfg_wr_en         | i_cfg_index, i_cfg_data
//
// one request per cycle sustained unless i_stall holds the output; results pass s1, s2, s3 and the output register
// the history ring is kept twice so both outgoing samples are read in the accept cycle
// sync active-low reset; no clearing pass, history is only read once written
// each stage advances when the one after it is empty or moving, so bubbles collapse
//   and a request is still taken while a result waits on a stalled output if a stage is empty
module moving_average_crossover_detector_top
    import mac_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF,
    parameter int PRICE_BITS = PRICE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_data,
    // sample requests
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [PRICE_BITS-1:0] i_price,
    input  logic                  i_start_of_series,
    // crossing results
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [1:0]            o_cross_signal
);

    localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
    localparam int HIST_W = (PRICE_BITS < SUM_W) ? PRICE_BITS : SUM_W;
    localparam int CMP_W  = (WIN_W > CFG_W) ? WIN_W : CFG_W;

    // configuration registers
    logic [CFG_W-1:0] r_fast_window, r_slow_window;

    // stage occupancy
    logic r_s1_valid, r_s2_valid, r_s3_valid, r_out_valid;

    logic [WIN_W-1:0] fast_window, slow_window;
    logic [CMP_W-1:0] fast_ext, slow_ext;

    logic      out_free, s3_free, s2_free, s1_free;
    logic      move3, move2, move1, accept;
    t_pipe_ctl ctl;

    // stage 1 payload
    logic [HIST_W-1:0] s1_price, s1_fast_old, s1_slow_old;
    logic [WIN_W-1:0]  s1_idx;
    logic              s1_start;

    // stage 2 payload
    logic [SUM_W-1:0] s2_short_sum, s2_long_sum;
    logic [WIN_W-1:0] s2_fast_count, s2_slow_count;
    logic             s2_gate, s2_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fast_window <= FAST_WINDOW_RESET;
            r_slow_window <= SLOW_WINDOW_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_FAST_WINDOW: r_fast_window <= i_cfg_data;
                REG_SLOW_WINDOW: r_slow_window <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // window zero acts as one, windows above the ring depth saturate
    always_comb begin
        fast_ext = CMP_W'(r_fast_window);
        slow_ext = CMP_W'(r_slow_window);

        if (fast_ext == '0) begin
            fast_window = WIN_W'(1);
        end else if (fast_ext > CMP_W'(MAX_WINDOW)) begin
            fast_window = WIN_W'(MAX_WINDOW);
        end else begin
            fast_window = fast_ext[WIN_W-1:0];
        end

        if (slow_ext == '0) begin
            slow_window = WIN_W'(1);
        end else if (slow_ext > CMP_W'(MAX_WINDOW)) begin
            slow_window = WIN_W'(MAX_WINDOW);
        end else begin
            slow_window = slow_ext[WIN_W-1:0];
        end
    end

    // elastic pipeline: a stage moves on when its successor can take it
    always_comb begin
        out_free = !r_out_valid || !i_stall;
        move3    = r_s3_valid && out_free;
        s3_free  = !r_s3_valid || move3;
        move2    = r_s2_valid && s3_free;
        s2_free  = !r_s2_valid || move2;
        move1    = r_s1_valid && s2_free;
        s1_free  = !r_s1_valid || move1;
        accept   = i_valid && s1_free;

        ctl.load_s1  = accept;
        ctl.load_s2  = move1;
        ctl.load_s3  = move2;
        ctl.load_out = move3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_valid <= accept;
            end
            if (s2_free) begin
                r_s2_valid <= move1;
            end
            if (s3_free) begin
                r_s3_valid <= move2;
            end
            if (out_free) begin
                r_out_valid <= move3;
            end
        end
    end

    // accept stage: ring write, outgoing sample reads, sample index
    mac_hist #(
        .MAX_WINDOW (MAX_WINDOW),
        .PRICE_BITS (PRICE_BITS),
        .WIN_W      (WIN_W),
        .HIST_W     (HIST_W)
    ) u_hist (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl),
        .i_price       (i_price),
        .i_start       (i_start_of_series),
        .i_fast_window (fast_window),
        .i_slow_window (slow_window),
        .o_price       (s1_price),
        .o_idx         (s1_idx),
        .o_start       (s1_start),
        .o_fast_old    (s1_fast_old),
        .o_slow_old    (s1_slow_old)
    );

    // sum update, read-modify-write of the two running sums
    mac_accum #(
        .MAX_WINDOW (MAX_WINDOW),
        .PRICE_BITS (PRICE_BITS),
        .WIN_W      (WIN_W),
        .HIST_W     (HIST_W)
    ) u_accum (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl),
        .i_price       (s1_price),
        .i_idx         (s1_idx),
        .i_start       (s1_start),
        .i_fast_old    (s1_fast_old),
        .i_slow_old    (s1_slow_old),
        .i_fast_window (fast_window),
        .i_slow_window (slow_window),
        .o_short_sum   (s2_short_sum),
        .o_long_sum    (s2_long_sum),
        .o_fast_count  (s2_fast_count),
        .o_slow_count  (s2_slow_count),
        .o_gate        (s2_gate),
        .o_start       (s2_start)
    );

    // products, compare and crossing decision into the output register
    mac_cross #(
        .MAX_WINDOW (MAX_WINDOW),
        .WIN_W      (WIN_W)
    ) u_cross (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .i_short_sum    (s2_short_sum),
        .i_long_sum     (s2_long_sum),
        .i_fast_count   (s2_fast_count),
        .i_slow_count   (s2_slow_count),
        .i_gate         (s2_gate),
        .i_start        (s2_start),
        .o_cross_signal (o_cross_signal)
    );

    assign o_stall = !s1_free;
    assign o_valid = r_out_valid;

endmodule

### rtl/mac_ram.sv
// generic single write port, single read port ram with registered read
// read returns the old contents when the same address is written in that cycle
// no dependencies
module mac_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/mac_hist.sv
// price history: write pointer, sample count and two copies of the ring
// one copy per window so both outgoing samples are read in the same cycle
// depends on mac_pkg and mac_ram
module mac_hist
    import mac_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF,
    parameter int PRICE_BITS = PRICE_BITS_DEF,
    parameter int WIN_W      = $clog2(MAX_WINDOW + 1),
    parameter int HIST_W     = (PRICE_BITS < SUM_W) ? PRICE_BITS : SUM_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_pipe_ctl             i_ctl,
    input  logic [PRICE_BITS-1:0] i_price,
    input  logic                  i_start,
    input  logic [WIN_W-1:0]      i_fast_window,
    input  logic [WIN_W-1:0]      i_slow_window,
    output logic [HIST_W-1:0]     o_price,
    output logic [WIN_W-1:0]      o_idx,
    output logic                  o_start,
    output logic [HIST_W-1:0]     o_fast_old,
    output logic [HIST_W-1:0]     o_slow_old
);

    localparam int PTR_W = $clog2(MAX_WINDOW);
    localparam int EXT_W = WIN_W + 1;

    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [WIN_W-1:0]  r_count, n_count;
    logic [HIST_W-1:0] r_price;
    logic [WIN_W-1:0]  r_idx;
    logic              r_start;

    logic [WIN_W-1:0]  idx;
    logic [HIST_W-1:0] price_trunc;
    logic [EXT_W-1:0]  ptr_x, fast_x, slow_x, fast_back, slow_back;
    logic [PTR_W-1:0]  fast_addr, slow_addr;

    assign price_trunc = i_price[HIST_W-1:0];

    always_comb begin
        idx = i_start ? '0 : r_count;

        if (idx < WIN_W'(MAX_WINDOW)) begin
            n_count = idx + 1'b1;
        end else begin
            n_count = WIN_W'(MAX_WINDOW);
        end

        if (r_wr_ptr == PTR_W'(MAX_WINDOW - 1)) begin
            n_wr_ptr = '0;
        end else begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end

        // ring position of the sample that leaves each window
        ptr_x  = EXT_W'(r_wr_ptr);
        fast_x = EXT_W'(i_fast_window);
        slow_x = EXT_W'(i_slow_window);
        if (fast_x > ptr_x) begin
            fast_back = ptr_x + EXT_W'(MAX_WINDOW) - fast_x;
        end else begin
            fast_back = ptr_x - fast_x;
        end
        if (slow_x > ptr_x) begin
            slow_back = ptr_x + EXT_W'(MAX_WINDOW) - slow_x;
        end else begin
            slow_back = ptr_x - slow_x;
        end
        fast_addr = fast_back[PTR_W-1:0];
        slow_addr = slow_back[PTR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_count  <= '0;
        end else if (i_ctl.load_s1) begin
            r_wr_ptr <= n_wr_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_s1) begin
            r_price <= price_trunc;
            r_idx   <= idx;
            r_start <= i_start;
        end
    end

    mac_ram #(
        .WIDTH (HIST_W),
        .DEPTH (MAX_WINDOW),
        .AW    (PTR_W)
    ) u_fast_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_ctl.load_s1),
        .i_wr_addr (r_wr_ptr),
        .i_wr_data (price_trunc),
        .i_rd_en   (i_ctl.load_s1),
        .i_rd_addr (fast_addr),
        .o_rd_data (o_fast_old)
    );

    mac_ram #(
        .WIDTH (HIST_W),
        .DEPTH (MAX_WINDOW),
        .AW    (PTR_W)
    ) u_slow_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_ctl.load_s1),
        .i_wr_addr (r_wr_ptr),
        .i_wr_data (price_trunc),
        .i_rd_en   (i_ctl.load_s1),
        .i_rd_addr (slow_addr),
        .o_rd_data (o_slow_old)
    );

    assign o_price = r_price;
    assign o_idx   = r_idx;
    assign o_start = r_start;

endmodule

### rtl/mac_accum.sv
// running window sums and effective sample counts of both averages
// the sum registers double as the payload of the next stage
// depends on mac_pkg
module mac_accum
    import mac_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF,
    parameter int PRICE_BITS = PRICE_BITS_DEF,
    parameter int WIN_W      = $clog2(MAX_WINDOW + 1),
    parameter int HIST_W     = (PRICE_BITS < SUM_W) ? PRICE_BITS : SUM_W
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_pipe_ctl         i_ctl,
    input  logic [HIST_W-1:0] i_price,
    input  logic [WIN_W-1:0]  i_idx,
    input  logic              i_start,
    input  logic [HIST_W-1:0] i_fast_old,
    input  logic [HIST_W-1:0] i_slow_old,
    input  logic [WIN_W-1:0]  i_fast_window,
    input  logic [WIN_W-1:0]  i_slow_window,
    output logic [SUM_W-1:0]  o_short_sum,
    output logic [SUM_W-1:0]  o_long_sum,
    output logic [WIN_W-1:0]  o_fast_count,
    output logic [WIN_W-1:0]  o_slow_count,
    output logic              o_gate,
    output logic              o_start
);

    localparam int EXT_W = WIN_W + 1;

    logic [SUM_W-1:0] r_short_sum, n_short_sum;
    logic [SUM_W-1:0] r_long_sum, n_long_sum;
    logic [WIN_W-1:0] r_fast_count, n_fast_count;
    logic [WIN_W-1:0] r_slow_count, n_slow_count;
    logic             r_gate, r_start;

    logic [SUM_W-1:0] short_base, long_base, price_ext, fast_drop, slow_drop;
    logic [EXT_W-1:0] idx_next;

    always_comb begin
        short_base = i_start ? '0 : r_short_sum;
        long_base  = i_start ? '0 : r_long_sum;
        price_ext  = SUM_W'(i_price);
        fast_drop  = (i_idx >= i_fast_window) ? SUM_W'(i_fast_old) : '0;
        slow_drop  = (i_idx >= i_slow_window) ? SUM_W'(i_slow_old) : '0;

        n_short_sum = short_base + price_ext - fast_drop;
        n_long_sum  = long_base + price_ext - slow_drop;

        // samples in each average so far, capped by the window
        idx_next = EXT_W'(i_idx) + 1'b1;
        if (idx_next < EXT_W'(i_fast_window)) begin
            n_fast_count = idx_next[WIN_W-1:0];
        end else begin
            n_fast_count = i_fast_window;
        end
        if (idx_next < EXT_W'(i_slow_window)) begin
            n_slow_count = idx_next[WIN_W-1:0];
        end else begin
            n_slow_count = i_slow_window;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_sum <= '0;
            r_long_sum  <= '0;
        end else if (i_ctl.load_s2) begin
            r_short_sum <= n_short_sum;
            r_long_sum  <= n_long_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_s2) begin
            r_fast_count <= n_fast_count;
            r_slow_count <= n_slow_count;
            r_gate       <= (i_idx >= i_slow_window);
            r_start      <= i_start;
        end
    end

    assign o_short_sum  = r_short_sum;
    assign o_long_sum   = r_long_sum;
    assign o_fast_count = r_fast_count;
    assign o_slow_count = r_slow_count;
    assign o_gate       = r_gate;
    assign o_start      = r_start;

endmodule

### rtl/mac_cross.sv
// cross-multiplied comparison of the two averages and crossing decision
// one stage of products, then compare against the previous relation
// depends on mac_pkg
module mac_cross
    import mac_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF,
    parameter int WIN_W      = $clog2(MAX_WINDOW + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_pipe_ctl        i_ctl,
    input  logic [SUM_W-1:0] i_short_sum,
    input  logic [SUM_W-1:0] i_long_sum,
    input  logic [WIN_W-1:0] i_fast_count,
    input  logic [WIN_W-1:0] i_slow_count,
    input  logic             i_gate,
    input  logic             i_start,
    output logic [1:0]       o_cross_signal
);

    localparam int PROD_W = SUM_W + WIN_W;

    logic [PROD_W-1:0] r_lhs, r_rhs;
    logic              r_gate, r_start;
    t_relation         r_prev_rel, n_prev_rel;
    t_cross            r_cross, n_cross;
    t_relation         prev_rel;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_s3) begin
            r_lhs   <= PROD_W'(i_short_sum) * PROD_W'(i_slow_count);
            r_rhs   <= PROD_W'(i_long_sum) * PROD_W'(i_fast_count);
            r_gate  <= i_gate;
            r_start <= i_start;
        end
    end

    always_comb begin
        prev_rel = r_start ? REL_EQUAL : r_prev_rel;

        if (r_lhs > r_rhs) begin
            n_prev_rel = REL_GREATER;
        end else if (r_lhs < r_rhs) begin
            n_prev_rel = REL_LESS;
        end else begin
            n_prev_rel = REL_EQUAL;
        end

        n_cross = CROSS_NONE;
        if (r_gate) begin
            if (prev_rel != REL_GREATER && n_prev_rel == REL_GREATER) begin
                n_cross = CROSS_UP;
            end else if (prev_rel != REL_LESS && n_prev_rel == REL_LESS) begin
                n_cross = CROSS_DOWN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_rel <= REL_EQUAL;
        end else if (i_ctl.load_out) begin
            r_prev_rel <= n_prev_rel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_out) begin
            r_cross <= n_cross;
        end
    end

    assign o_cross_signal = r_cross;

endmodule

### tb/moving_average_crossover_detector_checker.sv
// crossing checker: watches the config port and both channels of the detector,
// predicts each cross_signal from its own copy of the state and compares in order
// depends on mac_pkg for the register indexes, reset windows and result codes
module moving_average_crossover_detector_checker
    import mac_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_W-1:0]        i_cfg_data,
    input  logic                    i_in_valid,
    input  logic                    i_in_stall,
    input  logic [PRICE_BITS_DEF-1:0] i_price,
    input  logic                    i_start_of_series,
    input  logic                    i_out_valid,
    input  logic                    i_out_stall,
    input  logic [1:0]              i_cross_signal,
    output int unsigned             o_fail_count,
    output int unsigned             o_pending,
    output int unsigned             o_results_checked,
    output int unsigned             o_up_count,
    output int unsigned             o_down_count
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [PRICE_BITS_DEF-1:0] price_ring [MAX_WINDOW_DEF];
    logic [7:0]       ring_ptr;
    logic [8:0]       samples_seen;
    logic [SUM_W-1:0] short_total;
    logic [SUM_W-1:0] long_total;
    t_relation        last_relation;
    logic [CFG_W-1:0] fast_reg;
    logic [CFG_W-1:0] slow_reg;

    t_cross      crossing_q [$];
    t_cross      wanted;
    int unsigned fail_count;
    int unsigned results_checked;
    int unsigned up_count;
    int unsigned down_count;

    assign o_fail_count      = fail_count;
    assign o_results_checked = results_checked;
    assign o_up_count        = up_count;
    assign o_down_count      = down_count;

    // zero acts as one, anything past the ring depth acts as the full ring
    function automatic int unsigned window_len(logic [CFG_W-1:0] reg_value);
        if (reg_value == 0)
            return 1;
        if (reg_value > MAX_WINDOW_DEF)
            return MAX_WINDOW_DEF;
        return 32'(reg_value);
    endfunction

    function automatic t_cross predict_crossing(logic [PRICE_BITS_DEF-1:0] price,
                                                logic restart);
        int unsigned fast_len;
        int unsigned slow_len;
        int unsigned pos;
        int unsigned fast_cnt;
        int unsigned slow_cnt;
        logic [7:0]  old_slot;
        logic [63:0] fast_side;
        logic [63:0] slow_side;
        t_relation   rel;
        t_cross      sig;

        fast_len = window_len(fast_reg);
        slow_len = window_len(slow_reg);
        sig      = CROSS_NONE;

        if (restart) begin
            short_total   = '0;
            long_total    = '0;
            samples_seen  = '0;
            last_relation = REL_EQUAL;
        end

        pos         = 32'(samples_seen);
        short_total = short_total + SUM_W'(price);
        long_total  = long_total + SUM_W'(price);
        // ring index wraps at 8 bits, a full-ring window lands on the write slot
        if (pos >= fast_len) begin
            old_slot    = ring_ptr - 8'(fast_len);
            short_total = short_total - SUM_W'(price_ring[old_slot]);
        end
        if (pos >= slow_len) begin
            old_slot   = ring_ptr - 8'(slow_len);
            long_total = long_total - SUM_W'(price_ring[old_slot]);
        end

        price_ring[ring_ptr] = price;
        ring_ptr = ring_ptr + 8'd1;

        fast_cnt  = (pos + 1 < fast_len) ? pos + 1 : fast_len;
        slow_cnt  = (pos + 1 < slow_len) ? pos + 1 : slow_len;
        fast_side = 64'(short_total) * 64'(slow_cnt);
        slow_side = 64'(long_total) * 64'(fast_cnt);
        if (fast_side > slow_side)
            rel = REL_GREATER;
        else if (fast_side < slow_side)
            rel = REL_LESS;
        else
            rel = REL_EQUAL;

        if (pos >= slow_len) begin
            if (last_relation != REL_GREATER && rel == REL_GREATER)
                sig = CROSS_UP;
            else if (last_relation != REL_LESS && rel == REL_LESS)
                sig = CROSS_DOWN;
        end

        last_relation = rel;
        if (samples_seen < MAX_WINDOW_DEF)
            samples_seen = samples_seen + 9'd1;
        return sig;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            crossing_q.delete();
            ring_ptr      = '0;
            samples_seen  = '0;
            short_total   = '0;
            long_total    = '0;
            last_relation = REL_EQUAL;
            fast_reg      = FAST_WINDOW_RESET;
            slow_reg      = SLOW_WINDOW_RESET;
        end else begin
            if (i_cfg_wr_en) begin
                if (i_cfg_index == REG_FAST_WINDOW)
                    fast_reg = i_cfg_data;
                else if (i_cfg_index == REG_SLOW_WINDOW)
                    slow_reg = i_cfg_data;
            end
            // results lag their request, so retire before predicting this edge's request
            if (i_out_valid && !i_out_stall) begin
                if (crossing_q.size() == 0) begin
                    $error("cross_signal: no request outstanding, got %0d", i_cross_signal);
                    fail_count++;
                end else begin
                    wanted = crossing_q.pop_front();
                    results_checked++;
                    if (i_cross_signal !== wanted) begin
                        $error("cross_signal: expected %0d, got %0d", wanted, i_cross_signal);
                        fail_count++;
                    end else if (wanted == CROSS_UP) begin
                        up_count++;
                    end else if (wanted == CROSS_DOWN) begin
                        down_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                crossing_q.push_back(predict_crossing(i_price, i_start_of_series));
        end
        // registered so the stimulus side reads a settled count after each edge
        o_pending <= crossing_q.size();
    end

endmodule

### tb/moving_average_crossover_detector_top_test.sv
// top of the crossover detector testbench: clock, reset, config writes and price requests
// depends on mac_pkg, the detector rtl and moving_average_crossover_detector_checker
module moving_average_crossover_detector_top_test
    import mac_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_REQUESTS = 1600;
    // one result per request; idle time at the end lets the pipeline drain
    localparam int DRAIN_CYCLES    = 12;

    logic                      i_clk;
    logic                      i_rst_n           = 1'b0;
    logic                      i_cfg_wr_en       = 1'b0;
    logic [CFG_IDX_W-1:0]      i_cfg_index       = REG_FAST_WINDOW;
    logic [CFG_W-1:0]          i_cfg_data        = '0;
    logic                      i_valid           = 1'b0;
    logic                      o_stall;
    logic [PRICE_BITS_DEF-1:0] i_price           = '0;
    logic                      i_start_of_series = 1'b0;
    logic                      o_valid;
    logic                      i_stall           = 1'b0;
    logic [1:0]                o_cross_signal;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned results_checked;
    int unsigned up_count;
    int unsigned down_count;

    // bookkeeping for the stimulus side
    int unsigned               requests_sent;
    int unsigned               window_settings;
    logic [PRICE_BITS_DEF-1:0] price_level = 32'd1_000_000;
    // both sides stop idling while this is set
    bit                        steady;

    moving_average_crossover_detector_top DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_price          (i_price),
        .i_start_of_series(i_start_of_series),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_cross_signal   (o_cross_signal)
    );

    moving_average_crossover_detector_checker checker_i (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_valid),
        .i_in_stall       (o_stall),
        .i_price          (i_price),
        .i_start_of_series(i_start_of_series),
        .i_out_valid      (o_valid),
        .i_out_stall      (i_stall),
        .i_cross_signal   (o_cross_signal),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_results_checked(results_checked),
        .o_up_count       (up_count),
        .o_down_count     (down_count)
    );

    // 8 ns clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // result side backpressure, raised at random about 17 times in a hundred
    always @(posedge i_clk) begin
        i_stall <= !steady && ($urandom_range(99) < 17);
    end

    // hard stop in case the pipeline hangs
    initial begin
        #4_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // both window registers, back to back, only while nothing is in flight
    task automatic write_windows(input logic [CFG_W-1:0] fast_len,
                                 input logic [CFG_W-1:0] slow_len);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= REG_FAST_WINDOW;
        i_cfg_data  <= fast_len;
        @(posedge i_clk);
        i_cfg_index <= REG_SLOW_WINDOW;
        i_cfg_data  <= slow_len;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        window_settings++;
    endtask

    // one price request; payload holds until the edge that takes it
    task automatic send_sample(input logic [PRICE_BITS_DEF-1:0] price,
                               input logic restart);
        while (!steady && $urandom_range(99) < 17) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_price           <= price;
        i_start_of_series <= restart;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        requests_sent++;
    endtask

    // sender goes quiet until every predicted result has been seen
    task automatic wait_all_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    // mostly a random walk so the averages actually cross, plus jumps and rails
    function automatic logic [PRICE_BITS_DEF-1:0] next_price_tick();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 5)
            return $urandom_range(1) ? '1 : '0;
        if (pick < 15)
            return $urandom();
        if (pick < 18)
            price_level = $urandom();
        price_level = price_level + $urandom_range(2000) - 1000;
        return price_level;
    endfunction

    // short windows most of the time, rails and the full register range now and then
    function automatic logic [CFG_W-1:0] pick_window(input int unsigned typical_max);
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 15) begin
            case ($urandom_range(5))
                0: return 9'd0;
                1: return 9'd1;
                2: return 9'd255;
                3: return 9'd256;
                4: return 9'd257;
                default: return 9'd511;
            endcase
        end
        if (pick < 30)
            return CFG_W'($urandom_range(511));
        return CFG_W'($urandom_range(typical_max, 1));
    endfunction

    initial begin
        int unsigned phase_len;
        logic        restart;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero fast window acts as one; rails on price, crossing up then down,
        // back to equal and crossing up again from equal
        write_windows(9'd0, 9'd3);
        send_sample(32'd100, 1'b1);
        send_sample(32'd100, 1'b0);
        send_sample(32'd100, 1'b0);
        send_sample(32'd100, 1'b0);
        send_sample('1, 1'b0);
        send_sample('0, 1'b0);
        send_sample('0, 1'b0);
        send_sample('0, 1'b0);
        send_sample(32'd7, 1'b0);
        wait_all_results();

        // oversized windows both saturate to the full ring, so averages match
        write_windows(9'd511, 9'd257);
        send_sample('1, 1'b1);
        send_sample('1, 1'b0);
        send_sample('0, 1'b0);
        send_sample('1, 1'b0);
        wait_all_results();

        // shrink both windows mid-series: sums go inconsistent
        write_windows(9'd1, 9'd2);
        send_sample('0, 1'b0);
        send_sample('1, 1'b0);
        send_sample('1, 1'b0);
        send_sample('0, 1'b0);
        wait_all_results();

        // full-ring fast window against the shortest slow one
        write_windows(9'd256, 9'd1);
        send_sample('1, 1'b1);
        send_sample('1, 1'b0);
        send_sample(32'd1, 1'b0);
        send_sample('0, 1'b0);
        wait_all_results();

        // random phases, each ends with a full drain so the windows can move;
        // a phase does not always restart the series, so old sums carry over
        while (requests_sent < RANDOM_REQUESTS + 21) begin
            write_windows(pick_window(12), pick_window(40));
            phase_len = $urandom_range(160, 20);
            for (int unsigned k = 0; k < phase_len; k++) begin
                steady  = requests_sent >= 600 && requests_sent < 900;
                restart = (k == 0 && $urandom_range(1)) || $urandom_range(99) < 2;
                send_sample(next_price_tick(), restart);
            end
            wait_all_results();
        end
        steady = 1'b0;

        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d price requests over %0d window settings",
                 requests_sent, window_settings);
        $display("compared %0d results: %0d upward and %0d downward crossings",
                 results_checked, up_count, down_count);
        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### filelist.f
rtl/mac_pkg.sv
rtl/mac_ram.sv
rtl/mac_hist.sv
rtl/mac_accum.sv
rtl/mac_cross.sv
rtl/moving_average_crossover_detector_top.sv
tb/moving_average_crossover_detector_checker.sv
tb/moving_average_crossover_detector_top_test.sv
